// ===== design/sspa_pkg.sv =====
`timescale 1ns / 1ps
package sspa_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam logic [32:0] CORDIC_GAIN_INV = 33'h026DD3B6A;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [15:0] ONE_Q15 = 16'd32768;
    localparam logic [30:0] ONE_Q30 = 31'h40000000;
    localparam logic [32:0] NEAR_EPS_RAW = 33'd6;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic signed [15:0] rz;
        logic               cull_en;
        logic [31:0]        near_d;
        logic [31:0]        far_d;
    } front_item_t;

    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/sspa_front.sv =====
`timescale 1ns / 1ps
module sspa_front
    import sspa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] listener_x,
    input  logic signed [31:0] listener_y,
    input  logic signed [31:0] listener_z,
    input  logic signed [15:0] right_x,
    input  logic signed [15:0] right_y,
    input  logic signed [15:0] right_z,
    input  logic signed [31:0] source_x,
    input  logic signed [31:0] source_y,
    input  logic signed [31:0] source_z,
    input  logic               cull_enable,
    input  logic [31:0]        near_distance,
    input  logic [31:0]        far_distance,
    output logic               item_valid,
    input  logic               item_ready,
    output front_item_t        item
);

    logic        valid_reg;
    logic        valid_next;
    front_item_t item_reg;
    logic        take;

    assign in_ready = !valid_reg || item_ready;
    assign take = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // form the offsets at full 33-bit width on transfer
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.dx      <= 33'(source_x) - 33'(listener_x);
            item_reg.dy      <= 33'(source_y) - 33'(listener_y);
            item_reg.dz      <= 33'(source_z) - 33'(listener_z);
            item_reg.rx      <= right_x;
            item_reg.ry      <= right_y;
            item_reg.rz      <= right_z;
            item_reg.cull_en <= cull_enable;
            item_reg.near_d  <= near_distance;
            item_reg.far_d   <= far_distance;
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;

endmodule

// ===== design/sspa_queue.sv =====
`timescale 1ns / 1ps
module sspa_queue
    import sspa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    output logic        push_ready,
    input  front_item_t push_item,
    output logic        pop_valid,
    input  logic        pop_ready,
    output front_item_t pop_item
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    front_item_t   mem [0:QUEUE_DEPTH-1];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic          push;
    logic          pop;

    assign push_ready = count_reg != (PW+1)'(QUEUE_DEPTH);
    assign pop_valid = count_reg != '0;
    assign push = push_valid && push_ready;
    assign pop = pop_valid && pop_ready;
    assign pop_item = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= PW'((wr_ptr_reg + 1'b1) % QUEUE_DEPTH);
            end
            if (pop)
            begin
                rd_ptr_reg <= PW'((rd_ptr_reg + 1'b1) % QUEUE_DEPTH);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW+1)'(QUEUE_DEPTH))
        else $error("queue count above depth");
    a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == (PW+1)'(QUEUE_DEPTH) && !pop_ready) |=> count_reg == (PW+1)'(QUEUE_DEPTH))
        else $error("full queue changed without pop");
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 && !push_valid) |=> count_reg == '0)
        else $error("empty queue filled without push");

endmodule

// ===== design/sspa_back.sv =====
`timescale 1ns / 1ps
module sspa_back
    import sspa_pkg::*;
#(
    parameter int TRIG_ITERATIONS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  front_item_t item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [32:0] distance,
    output logic        culled,
    output logic [15:0] attenuation,
    output logic [15:0] left_gain,
    output logic [15:0] right_gain
);

    localparam int NT = (TRIG_ITERATIONS < ATAN_ENTRIES) ? TRIG_ITERATIONS : ATAN_ENTRIES;
    localparam int SQ = 33;
    localparam int DV = 16;
    localparam int S_SUM = 1;
    localparam int S_SQ0 = S_SUM + 1;
    localparam int S_SET = S_SQ0 + SQ;
    localparam int S_DV0 = S_SET + 1;
    localparam int S_FIN = S_DV0 + DV;
    localparam int S_TH = S_FIN + 1;
    localparam int S_CO0 = S_TH + 1;
    localparam int S_MUL = S_CO0 + NT;
    localparam int LAT = S_MUL + 2;

    logic [LAT-1:0] v_reg;
    logic           en;
    logic           take;

    assign en = !v_reg[LAT-1] || out_ready;
    assign item_ready = en;
    assign take = item_valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[LAT-2:0], take};
        end
    end

    // squares and projections
    logic [65:0]        sq_reg [0:2];
    logic signed [48:0] pr_reg [0:2];
    logic               c0_cull_reg;
    logic [31:0]        c0_near_reg;
    logic [31:0]        c0_far_reg;
    logic [32:0]        m0;
    logic [32:0]        m1;
    logic [32:0]        m2;

    assign m0 = item.dx[32] ? 33'(-item.dx) : 33'(item.dx);
    assign m1 = item.dy[32] ? 33'(-item.dy) : 33'(item.dy);
    assign m2 = item.dz[32] ? 33'(-item.dz) : 33'(item.dz);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg[0]   <= m0 * m0;
            sq_reg[1]   <= m1 * m1;
            sq_reg[2]   <= m2 * m2;
            pr_reg[0]   <= item.dx * item.rx;
            pr_reg[1]   <= item.dy * item.ry;
            pr_reg[2]   <= item.dz * item.rz;
            c0_cull_reg <= item.cull_en;
            c0_near_reg <= item.near_d;
            c0_far_reg  <= item.far_d;
        end
    end

    // square root pipeline, one root bit a stage
    logic [65:0]        rad_reg  [0:SQ];
    logic [34:0]        rem_reg  [0:SQ];
    logic [32:0]        root_reg [0:SQ];
    logic signed [50:0] dot_reg  [0:SQ];
    logic               sc_reg   [0:SQ];
    logic [31:0]        sn_reg   [0:SQ];
    logic [31:0]        sf_reg   [0:SQ];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg[0]  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            dot_reg[0]  <= 51'(pr_reg[0]) + 51'(pr_reg[1]) + 51'(pr_reg[2]);
            sc_reg[0]   <= c0_cull_reg;
            sn_reg[0]   <= c0_near_reg;
            sf_reg[0]   <= c0_far_reg;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < SQ; gi++)
        begin : g_sqrt
            logic [36:0] rem_sh;
            logic [36:0] trial;
            assign rem_sh = {rem_reg[gi], rad_reg[gi][2*(SQ-1-gi)+1 -: 2]};
            assign trial = {2'b00, root_reg[gi][32:0], 2'b01};
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[gi+1] <= rad_reg[gi];
                    dot_reg[gi+1] <= dot_reg[gi];
                    sc_reg[gi+1]  <= sc_reg[gi];
                    sn_reg[gi+1]  <= sn_reg[gi];
                    sf_reg[gi+1]  <= sf_reg[gi];
                    if (rem_sh >= trial)
                    begin
                        rem_reg[gi+1]  <= 35'(rem_sh - trial);
                        root_reg[gi+1] <= {root_reg[gi][31:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[gi+1]  <= rem_sh[34:0];
                        root_reg[gi+1] <= {root_reg[gi][31:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    // classify attenuation and pan, then divide both
    logic [32:0] dist_w;
    logic [31:0] far_w;
    logic [31:0] near_w;
    logic [50:0] magdot_w;

    assign dist_w = root_reg[SQ];
    assign far_w = sf_reg[SQ];
    assign near_w = sn_reg[SQ];
    assign magdot_w = dot_reg[SQ][50] ? 51'(-dot_reg[SQ]) : 51'(dot_reg[SQ]);

    logic [32:0] d_dist_reg [0:DV];
    logic        d_cull_reg [0:DV];
    logic        d_ramp_reg [0:DV];
    logic        d_zero_reg [0:DV];
    logic        d_one_reg  [0:DV];
    logic [31:0] d_den_reg  [0:DV];
    logic [31:0] d_arem_reg [0:DV];
    logic [14:0] d_aq_reg   [0:DV];
    logic        d_eps_reg  [0:DV];
    logic        d_sat_reg  [0:DV];
    logic        d_neg_reg  [0:DV];
    logic [15:0] d_low_reg  [0:DV];
    logic [32:0] d_prem_reg [0:DV];
    logic [15:0] d_pq_reg   [0:DV];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_dist_reg[0] <= dist_w;
            d_cull_reg[0] <= sc_reg[SQ] && (far_w != '0) && (dist_w > {1'b0, far_w});
            d_ramp_reg[0] <= far_w > near_w;
            d_zero_reg[0] <= dist_w >= {1'b0, far_w};
            d_one_reg[0]  <= dist_w <= {1'b0, near_w};
            d_den_reg[0]  <= far_w - near_w;
            d_arem_reg[0] <= far_w - dist_w[31:0];
            d_aq_reg[0]   <= '0;
            d_eps_reg[0]  <= dist_w > NEAR_EPS_RAW;
            d_sat_reg[0]  <= magdot_w >= {2'b00, dist_w, 16'h0000};
            d_neg_reg[0]  <= dot_reg[SQ][50];
            d_low_reg[0]  <= magdot_w[15:0];
            d_prem_reg[0] <= magdot_w[48:16];
            d_pq_reg[0]   <= '0;
        end
    end

    generate
        for (gi = 0; gi < DV; gi++)
        begin : g_div
            logic [33:0] p_sh;
            logic [32:0] a_sh;
            assign p_sh = {d_prem_reg[gi], d_low_reg[gi][DV-1-gi]};
            assign a_sh = {d_arem_reg[gi], 1'b0};
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    d_dist_reg[gi+1] <= d_dist_reg[gi];
                    d_cull_reg[gi+1] <= d_cull_reg[gi];
                    d_ramp_reg[gi+1] <= d_ramp_reg[gi];
                    d_zero_reg[gi+1] <= d_zero_reg[gi];
                    d_one_reg[gi+1]  <= d_one_reg[gi];
                    d_den_reg[gi+1]  <= d_den_reg[gi];
                    d_eps_reg[gi+1]  <= d_eps_reg[gi];
                    d_sat_reg[gi+1]  <= d_sat_reg[gi];
                    d_neg_reg[gi+1]  <= d_neg_reg[gi];
                    d_low_reg[gi+1]  <= d_low_reg[gi];
                    if (p_sh >= {1'b0, d_dist_reg[gi]})
                    begin
                        d_prem_reg[gi+1] <= 33'(p_sh - {1'b0, d_dist_reg[gi]});
                        d_pq_reg[gi+1]   <= {d_pq_reg[gi][14:0], 1'b1};
                    end
                    else
                    begin
                        d_prem_reg[gi+1] <= p_sh[32:0];
                        d_pq_reg[gi+1]   <= {d_pq_reg[gi][14:0], 1'b0};
                    end
                    // attenuation quotient has one bit fewer; hold on the last step
                    if (gi == DV - 1)
                    begin
                        d_arem_reg[gi+1] <= d_arem_reg[gi];
                        d_aq_reg[gi+1]   <= d_aq_reg[gi];
                    end
                    else if (a_sh >= {1'b0, d_den_reg[gi]})
                    begin
                        d_arem_reg[gi+1] <= 32'(a_sh - {1'b0, d_den_reg[gi]});
                        d_aq_reg[gi+1]   <= {d_aq_reg[gi][13:0], 1'b1};
                    end
                    else
                    begin
                        d_arem_reg[gi+1] <= a_sh[31:0];
                        d_aq_reg[gi+1]   <= {d_aq_reg[gi][13:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    // final attenuation and pan offset
    logic [15:0] att_w;
    logic [15:0] pmag_w;
    logic [16:0] u_w;

    always_comb
    begin
        if (!d_ramp_reg[DV] || d_one_reg[DV])
        begin
            att_w = ONE_Q15;
        end
        else if (d_zero_reg[DV])
        begin
            att_w = '0;
        end
        else
        begin
            att_w = {1'b0, d_aq_reg[DV]};
        end
        if (!d_eps_reg[DV])
        begin
            pmag_w = '0;
        end
        else if (d_sat_reg[DV] || d_pq_reg[DV] > ONE_Q15)
        begin
            pmag_w = ONE_Q15;
        end
        else
        begin
            pmag_w = d_pq_reg[DV];
        end
        if (d_neg_reg[DV])
        begin
            u_w = 17'(ONE_Q15) - 17'(pmag_w);
        end
        else
        begin
            u_w = 17'(ONE_Q15) + 17'(pmag_w);
        end
    end

    logic [32:0] f_dist_reg [0:NT+2];
    logic        f_cull_reg [0:NT+2];
    logic [15:0] f_att_reg  [0:NT+2];
    logic [16:0] f_u_reg;
    logic signed [33:0] cx_reg [0:NT];
    logic signed [33:0] cy_reg [0:NT];
    logic signed [33:0] cz_reg [0:NT];
    logic [47:0] th_prod;

    assign th_prod = f_u_reg * HALF_PI_Q30;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_dist_reg[0] <= d_dist_reg[DV];
            f_cull_reg[0] <= d_cull_reg[DV];
            f_att_reg[0]  <= att_w;
            f_u_reg       <= u_w;
            f_dist_reg[1] <= f_dist_reg[0];
            f_cull_reg[1] <= f_cull_reg[0];
            f_att_reg[1]  <= f_att_reg[0];
            cx_reg[0]     <= {1'b0, CORDIC_GAIN_INV};
            cy_reg[0]     <= '0;
            cz_reg[0]     <= {2'b00, th_prod[47:16]};
        end
    end

    generate
        for (gi = 0; gi < NT; gi++)
        begin : g_cordic
            logic signed [33:0] xs;
            logic signed [33:0] ys;
            logic signed [33:0] at;
            assign xs = cx_reg[gi] >>> gi;
            assign ys = cy_reg[gi] >>> gi;
            assign at = {2'b00, atan_q30(gi)};
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    f_dist_reg[gi+2] <= f_dist_reg[gi+1];
                    f_cull_reg[gi+2] <= f_cull_reg[gi+1];
                    f_att_reg[gi+2]  <= f_att_reg[gi+1];
                    if (!cz_reg[gi][33])
                    begin
                        cx_reg[gi+1] <= cx_reg[gi] - ys;
                        cy_reg[gi+1] <= cy_reg[gi] + xs;
                        cz_reg[gi+1] <= cz_reg[gi] - at;
                    end
                    else
                    begin
                        cx_reg[gi+1] <= cx_reg[gi] + ys;
                        cy_reg[gi+1] <= cy_reg[gi] - xs;
                        cz_reg[gi+1] <= cz_reg[gi] + at;
                    end
                end
            end
        end
    endgenerate

    // clamp trig values, scale by attenuation, round
    logic [30:0] cos_w;
    logic [30:0] sin_w;
    logic [46:0] lp_reg;
    logic [46:0] rp_reg;
    logic [47:0] lr_w;
    logic [47:0] rr_w;

    always_comb
    begin
        if (cx_reg[NT][33])
        begin
            cos_w = '0;
        end
        else if (cx_reg[NT] > 34'(ONE_Q30))
        begin
            cos_w = ONE_Q30;
        end
        else
        begin
            cos_w = cx_reg[NT][30:0];
        end
        if (cy_reg[NT][33])
        begin
            sin_w = '0;
        end
        else if (cy_reg[NT] > 34'(ONE_Q30))
        begin
            sin_w = ONE_Q30;
        end
        else
        begin
            sin_w = cy_reg[NT][30:0];
        end
    end

    assign lr_w = {1'b0, lp_reg} + 48'h0000_2000_0000;
    assign rr_w = {1'b0, rp_reg} + 48'h0000_2000_0000;

    logic [32:0] o_dist_reg;
    logic        o_cull_reg;
    logic [15:0] o_att_reg;
    logic [15:0] o_left_reg;
    logic [15:0] o_right_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_dist_reg[NT+2] <= f_dist_reg[NT+1];
            f_cull_reg[NT+2] <= f_cull_reg[NT+1];
            f_att_reg[NT+2]  <= f_att_reg[NT+1];
            lp_reg           <= cos_w * f_att_reg[NT+1];
            rp_reg           <= sin_w * f_att_reg[NT+1];
            o_dist_reg       <= f_dist_reg[NT+2];
            o_cull_reg       <= f_cull_reg[NT+2];
            o_att_reg        <= f_att_reg[NT+2];
            o_left_reg       <= lr_w[45:30];
            o_right_reg      <= rr_w[45:30];
        end
    end

    assign out_valid = v_reg[LAT-1];
    assign distance = o_dist_reg;
    assign culled = o_cull_reg;
    assign attenuation = o_att_reg;
    assign left_gain = o_left_reg;
    assign right_gain = o_right_reg;

    a_att_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> attenuation <= ONE_Q15)
        else $error("attenuation above unity");
    a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_gain <= attenuation && right_gain <= attenuation))
        else $error("gain above attenuation");
    a_cull_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && culled) |-> distance != '0)
        else $error("culled source at zero distance");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(distance) && $stable(left_gain)))
        else $error("stalled result changed");

endmodule

// ===== design/spatial_sound_pan_attenuate.sv =====
`timescale 1ns / 1ps
// Path from input transfer to out_valid: the input stage, the queue, the 33-stage square root,
// the 16-stage dividers and one CORDIC stage per iteration, up to ATAN_ENTRIES iterations.
// Throughput: one item per cycle while the output is taken; a two-entry queue between
// the input stage and the compute pipeline absorbs output stalls.
// Reset: rst_n clears all valid bits and queue pointers; data registers are not reset.
module spatial_sound_pan_attenuate
    import sspa_pkg::*;
#(
    parameter int TRIG_ITERATIONS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] listener_x,
    input  logic signed [31:0] listener_y,
    input  logic signed [31:0] listener_z,
    input  logic signed [15:0] right_x,
    input  logic signed [15:0] right_y,
    input  logic signed [15:0] right_z,
    input  logic signed [31:0] source_x,
    input  logic signed [31:0] source_y,
    input  logic signed [31:0] source_z,
    input  logic               cull_enable,
    input  logic [31:0]        near_distance,
    input  logic [31:0]        far_distance,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [32:0]        distance,
    output logic               culled,
    output logic [15:0]        attenuation,
    output logic [15:0]        left_gain,
    output logic [15:0]        right_gain
);

    logic        f_valid;
    logic        f_ready;
    front_item_t f_item;
    logic        q_valid;
    logic        q_ready;
    front_item_t q_item;

    sspa_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .listener_x    (listener_x),
        .listener_y    (listener_y),
        .listener_z    (listener_z),
        .right_x       (right_x),
        .right_y       (right_y),
        .right_z       (right_z),
        .source_x      (source_x),
        .source_y      (source_y),
        .source_z      (source_z),
        .cull_enable   (cull_enable),
        .near_distance (near_distance),
        .far_distance  (far_distance),
        .item_valid    (f_valid),
        .item_ready    (f_ready),
        .item          (f_item)
    );

    sspa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    sspa_back #(
        .TRIG_ITERATIONS (TRIG_ITERATIONS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (q_valid),
        .item_ready  (q_ready),
        .item        (q_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .distance    (distance),
        .culled      (culled),
        .attenuation (attenuation),
        .left_gain   (left_gain),
        .right_gain  (right_gain)
    );

endmodule
